// ===== hdl/mmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults for the message mailbox table.
package mmt_pkg;

	// Field widths of the stream payload
	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int FPAY_W  = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	// Default sizes
	localparam int DEF_NUM_UNICAST   = 16;
	localparam int DEF_NUM_BROADCAST = 16;
	localparam int DEF_PAYLOAD_BITS  = 32;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 3'd0,
		OP_SEND  = 3'd1,
		OP_GET   = 3'd2,
		OP_BSEND = 3'd3,
		OP_BGET  = 3'd4
	} op_t;

	// Slot status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_IDLE   = 2'd0;
	localparam status_t ST_POSTED = 2'd1;
	localparam status_t ST_ACTIVE = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_SWEEP,
		S_FIN
	} state_t;

	// Request to the slot unit
	typedef struct packed {
		op_t     op;
		logic    in_range;
		status_t st;
	} slot_req_t;

	// Answer of the slot unit
	typedef struct packed {
		status_t st_next;
		logic    wr;
		logic    load_pay;
		logic    hit;
	} slot_rsp_t;

endpackage

// ===== hdl/mmt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mmt_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/mmt_slot_unit.sv =====
`timescale 1ns / 1ps
// Shared slot unit: ageing, send and get decisions on one slot status.
module mmt_slot_unit (
	input  mmt_pkg::slot_req_t req,
	output mmt_pkg::slot_rsp_t rsp
);

	import mmt_pkg::*;

	// one decision per cycle, used by both the sweep and single accesses
	always_comb begin
		rsp = '0;
		rsp.st_next = req.st;
		unique case (req.op)
			OP_TICK: begin
				// active ages to idle, posted to active, anything else stays
				if (req.st == ST_ACTIVE) begin
					rsp.st_next = ST_IDLE;
					rsp.wr      = 1'b1;
				end else if (req.st == ST_POSTED) begin
					rsp.st_next = ST_ACTIVE;
					rsp.wr      = 1'b1;
				end
			end
			OP_SEND, OP_BSEND: begin
				if (req.in_range && req.st == ST_IDLE) begin
					rsp.st_next  = ST_POSTED;
					rsp.wr       = 1'b1;
					rsp.load_pay = 1'b1;
				end
			end
			OP_GET: begin
				if (req.in_range && req.st == ST_ACTIVE) begin
					rsp.st_next = ST_IDLE;
					rsp.wr      = 1'b1;
					rsp.hit     = 1'b1;
				end
			end
			OP_BGET: begin
				// broadcast read leaves the slot untouched
				rsp.hit = req.in_range && req.st == ST_ACTIVE;
			end
			default: begin
				rsp.wr = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/message_mailbox_table.sv =====
`timescale 1ns / 1ps
// Top level of the message mailbox table: sequencer, slot tables and result register.
// The block takes one command at a time and answers every command with one result
// transfer. A send, get, broadcast send or broadcast get goes through accept, table
// read and update, where the read step is set by the registered read port of the
// slot RAM. A tick walks every slot of both tables through the single slot unit,
// one slot per cycle. Unknown operation codes go through accept and result load and
// answer with found low. The input is not ready while a command is in work; a
// finished result waits in the output register while the next command is taken.
// Reset clears per-slot valid flags, so no clearing pass is needed.
module message_mailbox_table #(
	parameter int NUM_UNICAST   = mmt_pkg::DEF_NUM_UNICAST,
	parameter int NUM_BROADCAST = mmt_pkg::DEF_NUM_BROADCAST,
	parameter int PAYLOAD_BITS  = mmt_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [3:0] msg_index, [35:4] payload_in, [39:36] zero
	input  logic [mmt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [2:0] operation
	input  logic [mmt_pkg::OP_W-1:0]         s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] payload_out
	output logic [mmt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [0] found
	output logic                             m_axis_tuser
);

	import mmt_pkg::*;

	localparam int PW  = (PAYLOAD_BITS < FPAY_W) ? PAYLOAD_BITS : FPAY_W;
	localparam int EW  = PW + 2;
	localparam int UAW = (NUM_UNICAST > 1) ? $clog2(NUM_UNICAST) : 1;
	localparam int BAW = (NUM_BROADCAST > 1) ? $clog2(NUM_BROADCAST) : 1;
	localparam int AW  = (UAW > BAW) ? UAW : BAW;
	localparam int NT  = NUM_UNICAST + NUM_BROADCAST;
	localparam int CW  = $clog2(NT + 1);

	state_t state_q, state_d;

	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [PW-1:0]    pay_q;
	logic             tbl_q;

	logic [CW-1:0] iss_q;
	logic          wb_vld_s1;
	logic          wb_tbl_s1;
	logic [AW-1:0] wb_addr_s1;

	logic                 out_valid_q;
	logic                 found_q;
	logic [M_TDATA_W-1:0] pout_q;

	logic [NUM_UNICAST-1:0]   vld_u_q;
	logic [NUM_BROADCAST-1:0] vld_b_q;

	logic           u_re, u_we, b_re, b_we;
	logic [UAW-1:0] u_raddr, u_waddr;
	logic [BAW-1:0] b_raddr, b_waddr;
	logic [EW-1:0]  u_rdata, b_rdata, wdata;

	logic          accept, slot_free, load_out, found_d;
	logic          issuing, iss_tbl;
	logic [CW-1:0] iss_addr;
	logic          cur_tbl, cur_vld, in_range;
	logic [AW-1:0] cur_addr;
	logic [EW-1:0] cur_word;
	slot_req_t     req;
	slot_rsp_t     rsp;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign slot_free = !out_valid_q || m_axis_tready;

	// sweep issue position
	assign issuing  = iss_q < CW'(NT);
	assign iss_tbl  = iss_q >= CW'(NUM_UNICAST);
	assign iss_addr = iss_tbl ? (iss_q - CW'(NUM_UNICAST)) : iss_q;

	// slot under decision: sweep write-back or the single command
	assign cur_tbl  = (state_q == S_SWEEP) ? wb_tbl_s1 : tbl_q;
	assign cur_addr = (state_q == S_SWEEP) ? wb_addr_s1 : AW'(idx_q);
	assign cur_word = cur_tbl ? b_rdata : u_rdata;
	assign cur_vld  = cur_tbl ? vld_b_q[BAW'(cur_addr)] : vld_u_q[UAW'(cur_addr)];
	assign in_range = tbl_q ? (32'(idx_q) < NUM_BROADCAST) : (32'(idx_q) < NUM_UNICAST);

	always_comb begin
		req.op       = (state_q == S_SWEEP) ? OP_TICK : op_q;
		req.in_range = (state_q == S_SWEEP) ? 1'b1 : in_range;
		req.st       = cur_vld ? cur_word[EW-1:PW] : ST_IDLE;
	end

	mmt_slot_unit u_slot (
		.req (req),
		.rsp (rsp)
	);

	assign wdata = {rsp.st_next, rsp.load_pay ? pay_q : cur_word[PW-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(s_axis_tuser))
						OP_TICK:                          state_d = S_SWEEP;
						OP_SEND, OP_GET, OP_BSEND, OP_BGET: state_d = S_READ;
						default:                          state_d = S_FIN;
					endcase
				end
			end
			S_READ:  state_d = S_EXEC;
			S_EXEC:  if (slot_free) state_d = S_IDLE;
			S_SWEEP: if (!issuing && !wb_vld_s1) state_d = S_FIN;
			S_FIN:   if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: RAM strobes, addresses and result load
	always_comb begin
		s_axis_tready = 1'b0;
		u_re     = 1'b0;
		b_re     = 1'b0;
		u_we     = 1'b0;
		b_we     = 1'b0;
		u_raddr  = UAW'(idx_q);
		b_raddr  = BAW'(idx_q);
		u_waddr  = UAW'(cur_addr);
		b_waddr  = BAW'(cur_addr);
		load_out = 1'b0;
		found_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			S_READ: begin
				u_re = !tbl_q;
				b_re = tbl_q;
			end
			S_EXEC: begin
				if (slot_free) begin
					load_out = 1'b1;
					found_d  = rsp.hit;
					u_we     = rsp.wr && !tbl_q;
					b_we     = rsp.wr && tbl_q;
				end
			end
			S_SWEEP: begin
				u_raddr = UAW'(iss_addr);
				b_raddr = BAW'(iss_addr);
				u_re    = issuing && !iss_tbl;
				b_re    = issuing && iss_tbl;
				u_we    = wb_vld_s1 && rsp.wr && !wb_tbl_s1;
				b_we    = wb_vld_s1 && rsp.wr && wb_tbl_s1;
			end
			S_FIN: begin
				load_out = slot_free;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= '0;
			wb_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			vld_u_q     <= '0;
			vld_b_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				iss_q <= '0;
			end else if (state_q == S_SWEEP && issuing) begin
				iss_q <= iss_q + CW'(1);
			end
			wb_vld_s1 <= (state_q == S_SWEEP) && issuing;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (u_we) begin
				vld_u_q[u_waddr] <= 1'b1;
			end
			if (b_we) begin
				vld_b_q[b_waddr] <= 1'b1;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_axis_tuser);
			idx_q <= s_axis_tdata[IDX_W-1:0];
			pay_q <= PW'(s_axis_tdata[IDX_W+FPAY_W-1:IDX_W]);
			tbl_q <= (op_t'(s_axis_tuser) == OP_BSEND) || (op_t'(s_axis_tuser) == OP_BGET);
		end
		if (state_q == S_SWEEP && issuing) begin
			wb_tbl_s1  <= iss_tbl;
			wb_addr_s1 <= AW'(iss_addr);
		end
		if (load_out) begin
			found_q <= found_d;
			pout_q  <= found_d ? M_TDATA_W'(cur_word[PW-1:0]) : '0;
		end
	end

	// slot tables: {status, payload} per entry
	mmt_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_UNICAST)
	) u_uni_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (wdata),
		.re    (u_re),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	mmt_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_BROADCAST)
	) u_bc_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pout_q;
	assign m_axis_tuser  = found_q;

endmodule

// ===== hdl/mmt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the message mailbox table, bound to the top level.
module mmt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [mmt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [mmt_pkg::OP_W-1:0]      s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mmt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a miss always carries a zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("miss with non-zero payload");

	// one command in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

endmodule

bind message_mailbox_table mmt_checker u_mmt_checker (.*);

// ===== bench/tb_message_mailbox_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the message mailbox table: a directed command table, then random traffic checked against a slot-table model.
module tb_message_mailbox_table;
	import mmt_pkg::*;

	// Codes outside the operation set, which the block must ignore
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam int N_UCAST     = DEF_NUM_UNICAST;
	localparam int N_BCAST     = DEF_NUM_BROADCAST;
	localparam int RAND_ITEMS  = 800;
	localparam int DRAIN_WAIT  = 2 * (N_UCAST + N_BCAST + 4);
	localparam int HOLD_AT     = 550;
	localparam int HOLD_CYCLES = 250;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// [3:0] msg_index, [35:4] payload_in, [39:36] zero
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	// [2:0] operation
	logic [OP_W-1:0]      s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [31:0] payload_out
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// [0] found
	logic                 m_axis_tuser;

	message_mailbox_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// One answer the block owes
	typedef struct packed {
		logic              found;
		logic [FPAY_W-1:0] word;
		logic [15:0]       tag;
	} answer_t;

	// One row of the directed part; typed rows carry their own answer
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [FPAY_W-1:0] pay;
		logic              typed;
		logic              found;
		logic [FPAY_W-1:0] word;
	} cmd_row_t;

	localparam int N_ROWS = 25;
	localparam cmd_row_t DIR_ROWS [0:N_ROWS-1] = '{
		'{OP_GET,   4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_BGET,  4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_SEND,  4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_SEND,  4'd0,  32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000}, // busy, ignored
		'{OP_GET,   4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}, // posted, not yet visible
		'{OP_BSEND, 4'd15, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_BSEND, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_SEND,  4'd15, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_TICK,  4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_GET,   4'd0,  32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{OP_GET,   4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}, // cleared by the get
		'{OP_BGET,  4'd15, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_BGET,  4'd15, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000}, // broadcast stays
		'{OP_BGET,  4'd0,  32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{OP_BSEND, 4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}, // busy, ignored
		'{OP_RSVD5, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_RSVD6, 4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_RSVD7, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_TICK,  4'd15, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_GET,   4'd15, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}, // aged out unread
		'{OP_BGET,  4'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}, // aged out
		'{OP_SEND,  4'd15, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000},
		'{OP_TICK,  4'd7,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
		'{OP_GET,   4'd15, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
		'{OP_SEND,  4'd9,  32'hC3C3_3C3C, 1'b0, 1'b0, 32'h0000_0000}
	};

	// Mirror of the slot tables
	status_t           ucast_st   [N_UCAST];
	logic [FPAY_W-1:0] ucast_word [N_UCAST];
	status_t           bcast_st   [N_BCAST];
	logic [FPAY_W-1:0] bcast_word [N_BCAST];

	answer_t pending_answers [$];
	int      n_sent = 0;
	int      n_answered = 0;
	int      n_errors = 0;
	bit      tx_quiet = 1'b0;
	bit      rx_quiet = 1'b0;

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// One tick step of a slot: active expires, posted becomes visible
	function automatic status_t aged(input status_t st);
		if (st == ST_ACTIVE)
			return ST_IDLE;
		if (st == ST_POSTED)
			return ST_ACTIVE;
		return st;
	endfunction

	// Apply one command to the mirror and return the answer it causes
	function automatic answer_t mailbox_answer(input logic [OP_W-1:0] op,
		input logic [IDX_W-1:0] idx, input logic [FPAY_W-1:0] pay);
		answer_t ans;
		ans = '0;
		case (op)
			OP_TICK: begin
				for (int i = 0; i < N_UCAST; i++)
					ucast_st[i] = aged(ucast_st[i]);
				for (int i = 0; i < N_BCAST; i++)
					bcast_st[i] = aged(bcast_st[i]);
			end
			OP_SEND: begin
				if (int'(idx) < N_UCAST && ucast_st[idx] == ST_IDLE) begin
					ucast_st[idx] = ST_POSTED;
					ucast_word[idx] = pay;
				end
			end
			OP_GET: begin
				if (int'(idx) < N_UCAST && ucast_st[idx] == ST_ACTIVE) begin
					ucast_st[idx] = ST_IDLE;
					ans.found = 1'b1;
					ans.word = ucast_word[idx];
				end
			end
			OP_BSEND: begin
				if (int'(idx) < N_BCAST && bcast_st[idx] == ST_IDLE) begin
					bcast_st[idx] = ST_POSTED;
					bcast_word[idx] = pay;
				end
			end
			OP_BGET: begin
				if (int'(idx) < N_BCAST && bcast_st[idx] == ST_ACTIVE) begin
					ans.found = 1'b1;
					ans.word = bcast_word[idx];
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input int tag,
		input logic [FPAY_W-1:0] got, input logic [FPAY_W-1:0] want);
		n_errors++;
		$display("%0t ns: mismatch on %s of item %0d: got %h, want %h",
			$time, what, tag, got, want);
	endtask

	// Offer one command and book its answer once the transfer happens
	task automatic offer(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [FPAY_W-1:0] pay, input bit typed = 1'b0,
		input logic t_found = 1'b0, input logic [FPAY_W-1:0] t_word = '0);
		answer_t ans;
		if (!tx_quiet && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, pay, idx};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		ans = mailbox_answer(op, idx, pay);
		if (typed) begin
			ans.found = t_found;
			ans.word = t_word;
		end
		ans.tag = n_sent[15:0];
		pending_answers.push_back(ans);
		n_sent++;
	endtask

	// Sender: reset, directed table, random traffic, drain and verdict
	initial begin
		bit                bc;
		logic [IDX_W-1:0]  slot;
		int                n_gets;
		bit                paused;
		paused = 1'b0;
		for (int i = 0; i < N_UCAST; i++) begin
			ucast_st[i] = ST_IDLE;
			ucast_word[i] = '0;
		end
		for (int i = 0; i < N_BCAST; i++) begin
			bcast_st[i] = ST_IDLE;
			bcast_word[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (DIR_ROWS[r])
			offer(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].pay,
				DIR_ROWS[r].typed, DIR_ROWS[r].found, DIR_ROWS[r].word);

		// Random part: mostly post / tick / fetch exchanges, the rest noise
		while (n_sent < N_ROWS + RAND_ITEMS) begin
			tx_quiet = (n_sent >= 300 && n_sent < 450);
			if (!paused && n_sent >= 200) begin
				// let everything outstanding come back before going on
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				wait (pending_answers.size() == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 99) < 60) begin
				bc = ($urandom_range(0, 2) == 0);
				slot = IDX_W'($urandom_range(0, $urandom_range(0, 1) ? 3 : 15));
				offer(bc ? OP_BSEND : OP_SEND, slot, $urandom);
				if ($urandom_range(0, 99) < 30)
					offer(bc ? OP_BSEND : OP_SEND, slot, $urandom);
				if ($urandom_range(0, 3) != 0)
					offer(OP_TICK, IDX_W'($urandom), $urandom);
				n_gets = $urandom_range(1, 3);
				repeat (n_gets)
					offer(bc ? OP_BGET : OP_GET,
						($urandom_range(0, 4) == 0) ? IDX_W'($urandom) : slot, $urandom);
			end else begin
				if ($urandom_range(0, 4) == 0)
					offer(OP_TICK, IDX_W'($urandom), $urandom);
				else
					offer(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), $urandom);
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain
		wait (pending_answers.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0 && pending_answers.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver: check each result transfer, pace tready
	initial begin
		answer_t want;
		bit      held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected result", -1, m_axis_tdata, '0);
				end else begin
					want = pending_answers.pop_front();
					if (m_axis_tuser !== want.found)
						report_mismatch("found", int'(want.tag),
							FPAY_W'(m_axis_tuser), FPAY_W'(want.found));
					if (m_axis_tdata !== want.word)
						report_mismatch("payload", int'(want.tag), m_axis_tdata, want.word);
				end
				n_answered++;
			end
			rx_quiet = (n_answered >= 300 && n_answered < 450);
			if (!held && n_answered == HOLD_AT) begin
				// long hold-off so the block backs up into its input
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= rx_quiet || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== message_mailbox_table.f =====
hdl/mmt_pkg.sv
hdl/mmt_ram.sv
hdl/mmt_slot_unit.sv
hdl/message_mailbox_table.sv
hdl/mmt_checker.sv
bench/tb_message_mailbox_table.sv
